@@ hw/rtl/fiv_pkg.sv @@
// shared types, constants and functions of the font image validator
package fiv_pkg;

	localparam int unsigned HEADER_BYTES = 20;
	localparam int unsigned CRC_POSITION = 18;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [16:0] POS_MAX = 17'h1FFFF;
	localparam logic [17:0] USED_MAX = 18'h3FFFF;

	localparam logic [7:0] MAGIC_0 = 8'h50;
	localparam logic [7:0] MAGIC_1 = 8'h46;
	localparam logic [7:0] MAGIC_2 = 8'h4B;
	localparam logic [7:0] MAGIC_3 = 8'h31;

	// configuration register indexes
	localparam logic [1:0] REG_MAX_WIDTH = 2'd0;
	localparam logic [1:0] REG_MAX_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MAX_SIZE = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} fiv_in_t;

	typedef struct packed {
		logic        image_ok;
		logic        monospaced;
		logic [7:0]  font_width;
		logic [7:0]  glyph_height;
		logic [7:0]  base_advance;
		logic [3:0]  row_gap;
		logic [15:0] num_glyphs;
		logic [7:0]  range_count;
		logic [15:0] records_offset;
		logic [15:0] bmp_offset;
		logic [15:0] image_size;
	} fiv_out_t;

	typedef struct packed {
		logic [7:0]  width_cap;
		logic [7:0]  height_cap;
		logic [15:0] size_cap;
	} fiv_cfg_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic [16:0] pos;
		logic        crc_zero;
	} fiv_item_t;

	// one crc-16 byte update, msb first
	function automatic logic [15:0] crc_next(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/fiv_front.sv @@
// front end: byte position tracking and classification into the queue
module fiv_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fiv_pkg::fiv_in_t   in_data,
	output logic               q_valid,
	input  logic               q_ready,
	output fiv_pkg::fiv_item_t q_item
);
	import fiv_pkg::*;

	logic [16:0] pos_q;
	fiv_item_t   slot_q [QUEUE_DEPTH];
	logic        rd_ptr_q, wr_ptr_q;
	logic [1:0]  count_q;
	logic        push, pop;

	assign in_ready = (count_q != 2'(QUEUE_DEPTH));
	assign push = in_valid && in_ready;
	assign q_valid = (count_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_item = slot_q[rd_ptr_q];

	// position counter, restarts after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (in_data.last_byte) pos_q <= '0;
			else if (pos_q != POS_MAX) pos_q <= pos_q + 17'd1;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q].data <= in_data.data_byte;
			slot_q[wr_ptr_q].last <= in_data.last_byte;
			slot_q[wr_ptr_q].pos <= pos_q;
			slot_q[wr_ptr_q].crc_zero <= (pos_q == 17'(CRC_POSITION)) ||
				(pos_q == 17'(CRC_POSITION + 1));
		end
	end
endmodule

@@ hw/rtl/fiv_back.sv @@
// back end: header, entry and crc checks, verdict register
module fiv_back (
	input  logic               clk,
	input  logic               arst_n,
	input  fiv_pkg::fiv_cfg_t  cfg,
	input  logic               q_valid,
	output logic               q_ready,
	input  fiv_pkg::fiv_item_t q_item,
	output logic               out_valid,
	input  logic               out_ready,
	output fiv_pkg::fiv_out_t  out_data
);
	import fiv_pkg::*;

	logic [7:0]  hdr_q [16];
	logic [15:0] crc_q, crc_decl_q;
	logic        fail_q;
	logic [1:0]  phase_q;
	logic [15:0] partial_q;
	logic [7:0]  ranges_q;
	logic [16:0] prev_end_q, gir_q;
	logic [15:0] records_q;
	logic [17:0] used_q;
	logic [12:0] bpg_q;
	logic        out_valid_q;
	fiv_out_t    out_q;

	logic        take;
	logic [7:0]  b;
	logic [16:0] pos;
	logic [15:0] crc_n;
	logic        mono;
	logic [7:0]  rc;
	logic [15:0] gc, bmp, rec_off, dsize;
	logic        fail_n;
	logic        hdr_fail;
	logic [16:0] exp_rec;
	logic [17:0] exp_bmp;
	logic [12:0] bpg_n;
	logic        is_range, active;
	logic [16:0] r_end;
	logic [16:0] gir_n;
	logic [3:0]  rw_bytes;
	logic [12:0] rec_add;
	logic [18:0] used_sum;
	logic        entry_done;
	logic [17:0] used_n, used_v;
	logic [16:0] gir_v;
	logic [16:0] size;
	logic [28:0] mono_used;
	logic [29:0] total;
	logic        ok;

	assign q_ready = !out_valid_q || out_ready;
	assign take = q_valid && q_ready;
	assign b = q_item.data;
	assign pos = q_item.pos;
	assign crc_n = crc_next(crc_q, q_item.crc_zero ? 8'h00 : b);

	assign mono = hdr_q[0][0];
	assign rc = hdr_q[5];
	assign gc = {hdr_q[7], hdr_q[6]};
	assign rec_off = {hdr_q[9], hdr_q[8]};
	assign bmp = {hdr_q[11], hdr_q[10]};
	assign dsize = {hdr_q[13], hdr_q[12]};

	// header checks, with byte 19 live on the input
	always_comb begin
		exp_rec = 17'(HEADER_BYTES) + 17'({rc, 1'b0}) + 17'(rc);
		exp_bmp = 18'(exp_rec) + (mono ? 18'd0 : (18'({gc, 1'b0}) + 18'(gc)));
		hdr_fail = (hdr_q[0][7:1] != 7'd0) || (hdr_q[1] == 8'd0) ||
			(hdr_q[1] > cfg.width_cap) || (hdr_q[2] == 8'd0) ||
			(hdr_q[2] > cfg.height_cap) || (hdr_q[3] == 8'd0) ||
			(hdr_q[3] > cfg.width_cap) || (hdr_q[4] > 8'd15) ||
			(gc == 16'd0) || (rc == 8'd0) || (17'(rec_off) != exp_rec) ||
			(18'(bmp) != exp_bmp);
		bpg_n = 13'(({1'b0, hdr_q[1]} + 9'd7) >> 3) * 13'(hdr_q[2]);
	end

	// entry decode
	always_comb begin
		is_range = ranges_q < rc;
		active = is_range || (!mono && records_q < gc);
		r_end = 17'(partial_q) + 17'(b) + 17'd1;
		gir_n = gir_q + 17'(b) + 17'd1;
		rw_bytes = 4'((5'(b[7:4]) + 5'd8) >> 3);
		rec_add = 13'(rw_bytes) * 13'(hdr_q[2]);
		used_sum = 19'(used_q) + 19'(rec_add);
		used_n = (used_sum > 19'(USED_MAX)) ? USED_MAX : used_sum[17:0];
		entry_done = !fail_q && !pos[16] && pos >= 17'(HEADER_BYTES) && active &&
			phase_q == 2'd2;
		// totals including an entry that completes on this byte
		used_v = (entry_done && !is_range) ? used_n : used_q;
		gir_v = (entry_done && is_range) ? gir_n : gir_q;
	end

	// next fail state
	always_comb begin
		fail_n = fail_q || pos[16];
		if (!fail_n) begin
			case (pos)
				17'd0: fail_n = (b != MAGIC_0);
				17'd1: fail_n = (b != MAGIC_1);
				17'd2: fail_n = (b != MAGIC_2);
				17'd3: fail_n = (b != MAGIC_3);
				default: begin
					if (pos == 17'(HEADER_BYTES - 1)) begin
						fail_n = hdr_fail;
					end else if (pos >= 17'(HEADER_BYTES) && active && phase_q == 2'd2) begin
						if (is_range)
							fail_n = (ranges_q != 8'd0 && 17'(partial_q) < prev_end_q) ||
								(r_end > 17'h10000) || (gir_n > 17'(gc));
						else
							fail_n = (partial_q != 16'(used_q)) || (used_q[17:16] != 2'd0) ||
								(8'(b[7:4]) + 8'd1 > hdr_q[1]) ||
								(8'(b[3:0]) + 8'd1 > cfg.width_cap);
					end
				end
			endcase
		end
	end

	// final verdict
	always_comb begin
		size = pos + 17'd1;
		mono_used = 29'(bpg_q) * 29'(gc);
		total = 30'(bmp) + (mono ? 30'(mono_used) : 30'(used_v));
		ok = !fail_n && size >= 17'(HEADER_BYTES) && !size[16] &&
			size <= 17'(cfg.size_cap) && size >= 17'(CRC_POSITION + 2) &&
			dsize == size[15:0] && crc_decl_q == crc_n && 17'(bmp) <= size &&
			gir_v == 17'(gc) && total == 30'(size);
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			crc_decl_q <= '0;
			fail_q <= 1'b0;
			phase_q <= '0;
			partial_q <= '0;
			ranges_q <= '0;
			prev_end_q <= '0;
			gir_q <= '0;
			records_q <= '0;
			used_q <= '0;
			bpg_q <= '0;
		end else if (take) begin
			if (q_item.last) begin
				crc_q <= CRC_INIT;
				crc_decl_q <= '0;
				fail_q <= 1'b0;
				phase_q <= '0;
				partial_q <= '0;
				ranges_q <= '0;
				prev_end_q <= '0;
				gir_q <= '0;
				records_q <= '0;
				used_q <= '0;
				bpg_q <= '0;
			end else begin
				crc_q <= crc_n;
				fail_q <= fail_n;
				if (pos == 17'(CRC_POSITION)) crc_decl_q[7:0] <= b;
				if (pos == 17'(CRC_POSITION + 1)) crc_decl_q[15:8] <= b;
				if (!fail_q && !pos[16]) begin
					if (pos == 17'(HEADER_BYTES - 1) && !hdr_fail) bpg_q <= bpg_n;
					if (pos >= 17'(HEADER_BYTES) && active) begin
						case (phase_q)
							2'd0: begin
								partial_q <= {8'h00, b};
								phase_q <= 2'd1;
							end
							2'd1: begin
								partial_q[15:8] <= b;
								phase_q <= 2'd2;
							end
							default: begin
								phase_q <= 2'd0;
								if (is_range) begin
									prev_end_q <= r_end;
									gir_q <= gir_n;
									ranges_q <= ranges_q + 8'd1;
								end else begin
									used_q <= used_n;
									records_q <= records_q + 16'd1;
								end
							end
						endcase
					end
				end
			end
		end
	end

	// header bytes 4..19
	always_ff @(posedge clk) begin
		if (take && !fail_q && !pos[16] && pos >= 17'd4 && pos < 17'(HEADER_BYTES))
			hdr_q[4'(pos - 17'd4)] <= b;
	end

	// verdict output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && q_item.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && q_item.last) begin
			if (ok) begin
				out_q.image_ok <= 1'b1;
				out_q.monospaced <= mono;
				out_q.font_width <= hdr_q[1];
				out_q.glyph_height <= hdr_q[2];
				out_q.base_advance <= hdr_q[3];
				out_q.row_gap <= hdr_q[4][3:0];
				out_q.num_glyphs <= gc;
				out_q.range_count <= rc;
				out_q.records_offset <= rec_off;
				out_q.bmp_offset <= bmp;
				out_q.image_size <= size[15:0];
			end else begin
				out_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
endmodule

@@ hw/rtl/font_image_validator_core.sv @@
// top level of the font image validator
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | fiv_in_t (data_byte, last_byte)
//  out     | output    | out_valid/out_ready | fiv_out_t verdict, one per image
//  cfg     | input     | cfg_we              | cfg_index, cfg_wdata
// one byte per cycle sustained while the output is not stalled; a byte enters the
// two-entry queue on its transfer and the back end checks it as it leaves the queue,
// where the verdict register loads, so out_valid follows the queue slot and that register.
// reset clears the stream state except the stored header bytes, and loads default limits.
// a stalled output fills the queue, then in_ready drops.
module font_image_validator_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fiv_pkg::fiv_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output fiv_pkg::fiv_out_t out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_wdata
);
	import fiv_pkg::*;

	fiv_cfg_t  cfg_q;
	logic      q_valid, q_ready;
	fiv_item_t q_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_cap <= 8'd16;
			cfg_q.height_cap <= 8'd32;
			cfg_q.size_cap <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_WIDTH: cfg_q.width_cap <= cfg_wdata[7:0];
				REG_MAX_HEIGHT: cfg_q.height_cap <= cfg_wdata[7:0];
				REG_MAX_SIZE: cfg_q.size_cap <= cfg_wdata;
				default: ;
			endcase
		end
	end

	fiv_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	fiv_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_valid(q_valid), .q_ready(q_ready),
		.q_item(q_item), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule

@@ hw/rtl/fiv_checker.sv @@
// port-level checker for the font image validator and its bind
module fiv_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input fiv_pkg::fiv_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input fiv_pkg::fiv_out_t out_data
);
	logic [3:0] open_q;

	// last byte transfers not yet answered by a verdict transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 4'(in_valid && in_ready && in_data.last_byte) -
				4'(out_valid && out_ready);
		end
	end

	// failed verdict carries zero metrics
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.image_ok |-> out_data.image_size == 16'd0 &&
		out_data.num_glyphs == 16'd0 && out_data.font_width == 8'd0)
		else $error("failed verdict with nonzero fields");

	// a passing image is at least a header long
	a_ok_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.image_ok |-> out_data.image_size >= 16'd20)
		else $error("passing image shorter than header");

	// a verdict needs an unanswered last byte transfer
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> open_q != 4'd0)
		else $error("verdict without last byte");

	// stalled verdict holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("verdict changed while stalled");
endmodule

bind font_image_validator_core fiv_checker u_fiv_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
